// ===== hw/rtl/udp_endpoint_demux_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// udp_endpoint_demux_queue_core assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef UDP_ENDPOINT_DEMUX_QUEUE_CORE_ASSERT_SVH
`define UDP_ENDPOINT_DEMUX_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define UDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/udq_pkg.sv =====
// ----------------------------------------------------------------------------
// udq_pkg
// Shared constants, codes and the beat record that walks the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package udq_pkg;

	localparam int ENDPOINTS   = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int IFACES      = 16;

	localparam int SLOT_W  = 4;
	localparam int IFACE_W = 5;
	localparam int QCNT_W  = 4;
	localparam int LEN_W   = 16;

	localparam logic [IFACE_W-1:0] IFACE_ANY   = IFACE_W'(16);
	localparam logic [LEN_W-1:0]   MAXLEN_RST  = LEN_W'(1472);

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_CLASSIFY = 2'd1,
		CMD_CONSUME  = 2'd2,
		CMD_NONE     = 2'd3
	} udq_cmd_t;

	typedef enum logic [2:0] {
		ST_QUEUED   = 3'd0,
		ST_FULL     = 3'd1,
		ST_TOOLONG  = 3'd2,
		ST_NOMATCH  = 3'd3,
		ST_WRITTEN  = 3'd4,
		ST_CONSUMED = 3'd5,
		ST_EMPTY    = 3'd6
	} udq_status_t;

	typedef struct packed {
		udq_cmd_t            cmd;
		logic [SLOT_W-1:0]   slot;
		logic                entry_valid;
		logic [31:0]         host_ip;
		logic [15:0]         host_port;
		logic [31:0]         remote_ip;
		logic [15:0]         remote_port;
		logic [IFACE_W-1:0]  iface_index;
		logic [LEN_W-1:0]    length;
		logic                done;
		udq_status_t         status;
		logic [SLOT_W-1:0]   matched_slot;
		logic [QCNT_W-1:0]   queued_count;
		logic [31:0]         drop_count;
	} udq_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/udq_cell.sv =====
// ----------------------------------------------------------------------------
// udq_cell
// One endpoint entry. Checks the passing beat against its entry, applies
// write, classify or consume when it owns the beat, and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module udq_cell import udq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] idx,
	input  wire logic              adv,
	input  wire logic [LEN_W-1:0]  max_len,
	input  wire logic              vld_i,
	input  wire udq_beat_t         beat_i,
	output logic                   vld_o,
	output udq_beat_t              beat_o
);

	logic               valid_q;
	logic [31:0]        lip_q;
	logic [15:0]        lport_q;
	logic [IFACE_W-1:0] iface_q;
	logic [31:0]        rip_q;
	logic [15:0]        rport_q;
	logic [QCNT_W-1:0]  qcnt_q;
	logic [31:0]        drops_q;

	logic               arr_real;
	logic               hit;
	logic               own;
	logic               upd;
	udq_beat_t          beat_n;
	logic [QCNT_W-1:0]  qcnt_n;
	logic [31:0]        drops_n;

	always_comb begin
		arr_real = (int'(beat_i.iface_index) < IFACES) && (beat_i.iface_index != IFACE_ANY);
		hit = valid_q && (lport_q != '0) && (lport_q == beat_i.host_port)
			&& ((lip_q == '0) || (lip_q == beat_i.host_ip))
			&& ((iface_q == IFACE_ANY) || (arr_real && (iface_q == beat_i.iface_index)))
			&& ((rip_q == '0) || (rip_q == beat_i.remote_ip))
			&& ((rport_q == '0) || (rport_q == beat_i.remote_port));
		own     = 1'b0;
		beat_n  = beat_i;
		qcnt_n  = qcnt_q;
		drops_n = drops_q;
		if (!beat_i.done) begin
			case (beat_i.cmd)
				CMD_CLASSIFY: begin
					own = hit;
					if (int'(qcnt_q) >= QUEUE_DEPTH) begin
						drops_n       = drops_q + 32'd1;
						beat_n.status = ST_FULL;
					end else if (beat_i.length > max_len) begin
						drops_n       = drops_q + 32'd1;
						beat_n.status = ST_TOOLONG;
					end else begin
						qcnt_n        = qcnt_q + QCNT_W'(1);
						beat_n.status = ST_QUEUED;
					end
				end
				CMD_WRITE: begin
					own           = (beat_i.slot == idx);
					qcnt_n        = '0;
					drops_n       = '0;
					beat_n.status = ST_WRITTEN;
				end
				CMD_CONSUME: begin
					own = (beat_i.slot == idx);
					if (!valid_q || (qcnt_q == '0)) begin
						beat_n.status = ST_EMPTY;
					end else begin
						qcnt_n        = qcnt_q - QCNT_W'(1);
						beat_n.status = ST_CONSUMED;
					end
				end
				default: begin
					own = 1'b0;
				end
			endcase
		end
		beat_n.done         = beat_i.done || own;
		beat_n.matched_slot = own ? idx : beat_i.matched_slot;
		beat_n.queued_count = own ? qcnt_n : beat_i.queued_count;
		beat_n.drop_count   = own ? drops_n : beat_i.drop_count;
		if (!own) begin
			beat_n.status = beat_i.status;
		end
		upd = adv && vld_i && own;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lip_q   <= '0;
			lport_q <= '0;
			iface_q <= IFACE_ANY;
			rip_q   <= '0;
			rport_q <= '0;
			qcnt_q  <= '0;
			drops_q <= '0;
		end else if (upd) begin
			qcnt_q  <= qcnt_n;
			drops_q <= drops_n;
			if (beat_i.cmd == CMD_WRITE) begin
				valid_q <= beat_i.entry_valid;
				lip_q   <= beat_i.host_ip;
				lport_q <= beat_i.host_port;
				iface_q <= beat_i.iface_index;
				rip_q   <= beat_i.remote_ip;
				rport_q <= beat_i.remote_port;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_o <= beat_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/udp_endpoint_demux_queue_core.sv =====
// ----------------------------------------------------------------------------
// udp_endpoint_demux_queue_core
// UDP endpoint table as a row of cells; each request beat walks the row and
// is claimed by the lowest-numbered matching or addressed entry.
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       cmd slot entry_valid host_ip ...
//   out       out_valid / out_ready     status matched_slot queued_count ...
//   cfg       psel penable pwrite       paddr pwdata prdata (pready tied 1)
//
// Each beat passes every registered cell in turn, one per cycle unless stalled.
// Throughput: one beat per cycle unless stalled; beats keep order in the row.
// A stalled result freezes the whole row; in_ready drops with it.
// Reset: all entries free, interface any, counts zero, max length 1472.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_endpoint_demux_queue_core import udq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [SLOT_W-1:0]  slot,
	input  wire logic               entry_valid,
	input  wire logic [31:0]        host_ip,
	input  wire logic [15:0]        host_port,
	input  wire logic [31:0]        remote_ip,
	input  wire logic [15:0]        remote_port,
	input  wire logic [IFACE_W-1:0] iface_index,
	input  wire logic [LEN_W-1:0]   length,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [SLOT_W-1:0]       matched_slot,
	output logic [QCNT_W-1:0]       queued_count,
	output logic [31:0]             drop_count,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic               adv;
	logic [LEN_W-1:0]   max_len_q;
	logic               vld   [ENDPOINTS+1];
	udq_beat_t          beat  [ENDPOINTS+1];

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign adv      = !vld[ENDPOINTS] || out_ready;
	assign in_ready = adv;

	always_comb begin
		vld[0]               = in_valid;
		beat[0].cmd          = udq_cmd_t'(cmd);
		beat[0].slot         = slot;
		beat[0].entry_valid  = entry_valid;
		beat[0].host_ip      = host_ip;
		beat[0].host_port    = host_port;
		beat[0].remote_ip    = remote_ip;
		beat[0].remote_port  = remote_port;
		beat[0].iface_index  = iface_index;
		beat[0].length       = length;
		beat[0].done         = 1'b0;
		beat[0].status       = ST_NOMATCH;
		beat[0].matched_slot = '0;
		beat[0].queued_count = '0;
		beat[0].drop_count   = '0;
	end

	for (genvar i = 0; i < ENDPOINTS; i++) begin : g_cell
		udq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (SLOT_W'(i)),
			.adv     (adv),
			.max_len (max_len_q),
			.vld_i   (vld[i]),
			.beat_i  (beat[i]),
			.vld_o   (vld[i+1]),
			.beat_o  (beat[i+1])
		);
	end

	assign out_valid    = vld[ENDPOINTS];
	assign status       = beat[ENDPOINTS].status;
	assign matched_slot = beat[ENDPOINTS].matched_slot;
	assign queued_count = beat[ENDPOINTS].queued_count;
	assign drop_count   = beat[ENDPOINTS].drop_count;

endmodule

`default_nettype wire

// ===== hw/rtl/udq_checker.sv =====
// ----------------------------------------------------------------------------
// udq_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "udp_endpoint_demux_queue_core_assert.svh"

module udq_checker import udq_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [2:0]        status,
	input wire logic [SLOT_W-1:0] matched_slot,
	input wire logic [QCNT_W-1:0] queued_count,
	input wire logic [31:0]       drop_count
);

	`UDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drop_count) && $stable(status), "result beat changed while stalled")
	`UDQ_ASSERT_NOW(a_status_range, out_valid, status != 3'd7, "undefined status code")
	`UDQ_ASSERT_NOW(a_nomatch_zero, out_valid && (status == ST_NOMATCH), (matched_slot == '0) && (queued_count == '0) && (drop_count == '0), "no-match beat carries entry data")
	`UDQ_ASSERT_NOW(a_write_clear, out_valid && (status == ST_WRITTEN), (queued_count == '0) && (drop_count == '0), "write did not clear counts")
	`UDQ_ASSERT_NOW(a_qcnt_bound, out_valid, int'(queued_count) <= QUEUE_DEPTH, "queue count above depth")

endmodule

bind udp_endpoint_demux_queue_core udq_checker u_udq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.matched_slot (matched_slot),
	.queued_count (queued_count),
	.drop_count   (drop_count)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: UDP endpoint demux queue core testbench
// Programs endpoint entries, classifies datagram headers against them and
// consumes queued datagrams, checking every result beat against an in-bench
// model of the endpoint table, queue counts and drop counters. Runs a short
// directed sequence, then random phases under different max-length settings
// and source/sink idling.
// ----------------------------------------------------------------------------

module tb_top;
	import udq_pkg::*;

	localparam int REG_MAX_LEN  = 0;
	localparam int WDOG_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 150;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		udq_cmd_t            cmd;
		logic [SLOT_W-1:0]   slot;
		logic                entry_valid;
		logic [31:0]         host_ip;
		logic [15:0]         host_port;
		logic [31:0]         remote_ip;
		logic [15:0]         remote_port;
		logic [IFACE_W-1:0]  iface_index;
		logic [LEN_W-1:0]    length;
	} dgram_req_t;

	typedef struct packed {
		udq_status_t         status;
		logic [SLOT_W-1:0]   slot;
		logic [QCNT_W-1:0]   qcnt;
		logic [31:0]         drops;
	} sock_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	dgram_req_t drv = '0;

	wire logic in_ready;
	wire logic out_valid;
	wire logic [2:0] status;
	wire logic [SLOT_W-1:0] matched_slot;
	wire logic [QCNT_W-1:0] queued_count;
	wire logic [31:0] drop_count;
	wire logic [31:0] prdata;
	wire logic pready;

	udp_endpoint_demux_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (drv.cmd),
		.slot         (drv.slot),
		.entry_valid  (drv.entry_valid),
		.host_ip      (drv.host_ip),
		.host_port    (drv.host_port),
		.remote_ip    (drv.remote_ip),
		.remote_port  (drv.remote_port),
		.iface_index  (drv.iface_index),
		.length       (drv.length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.matched_slot (matched_slot),
		.queued_count (queued_count),
		.drop_count   (drop_count),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// endpoint table model
	logic                tbl_valid [ENDPOINTS];
	logic [31:0]         tbl_lip   [ENDPOINTS];
	logic [15:0]         tbl_lport [ENDPOINTS];
	logic [IFACE_W-1:0]  tbl_ifc   [ENDPOINTS];
	logic [31:0]         tbl_rip   [ENDPOINTS];
	logic [15:0]         tbl_rport [ENDPOINTS];
	logic [QCNT_W-1:0]   tbl_q     [ENDPOINTS];
	logic [31:0]         tbl_drops [ENDPOINTS];
	logic [LEN_W-1:0]    tbl_max_len = MAXLEN_RST;

	// what the stimulus has programmed, used to aim headers at entries
	logic [31:0]         aim_lip   [ENDPOINTS];
	logic [15:0]         aim_lport [ENDPOINTS];
	logic [IFACE_W-1:0]  aim_ifc   [ENDPOINTS];
	logic [31:0]         aim_rip   [ENDPOINTS];
	logic [15:0]         aim_rport [ENDPOINTS];
	logic [LEN_W-1:0]    cfg_max_len = MAXLEN_RST;

	dgram_req_t    dgram_q[$];
	sock_verdict_t verdict_q[$];

	int  src_idle_pct = 0;
	int  sink_stall_pct = 0;
	int  mismatch_cnt = 0;
	int  quiet_cycles = 0;
	logic in_took = 1'b0;

	function automatic bit ep_hit(input int e, input dgram_req_t r);
		bit arrival_real;
		arrival_real = (int'(r.iface_index) < IFACES) && (r.iface_index != IFACE_ANY);
		if (!tbl_valid[e])
			return 1'b0;
		if (tbl_lport[e] == '0 || tbl_lport[e] != r.host_port)
			return 1'b0;
		if (tbl_lip[e] != '0 && tbl_lip[e] != r.host_ip)
			return 1'b0;
		if (tbl_ifc[e] != IFACE_ANY && (!arrival_real || tbl_ifc[e] != r.iface_index))
			return 1'b0;
		if (tbl_rip[e] != '0 && tbl_rip[e] != r.remote_ip)
			return 1'b0;
		if (tbl_rport[e] != '0 && tbl_rport[e] != r.remote_port)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic sock_verdict_t socket_lookup(input dgram_req_t r);
		sock_verdict_t v;
		bit found;
		int s;
		v = '0;
		v.status = ST_NOMATCH;
		found = 1'b0;
		s = int'(r.slot);
		if (r.cmd == CMD_CLASSIFY) begin
			for (int e = 0; e < ENDPOINTS; e++) begin
				if (!found && ep_hit(e, r)) begin
					found = 1'b1;
					if (int'(tbl_q[e]) >= QUEUE_DEPTH) begin
						tbl_drops[e] = tbl_drops[e] + 32'd1;
						v.status = ST_FULL;
					end else if (r.length > tbl_max_len) begin
						tbl_drops[e] = tbl_drops[e] + 32'd1;
						v.status = ST_TOOLONG;
					end else begin
						tbl_q[e] = tbl_q[e] + QCNT_W'(1);
						v.status = ST_QUEUED;
					end
					v.slot = SLOT_W'(e);
					v.qcnt = tbl_q[e];
					v.drops = tbl_drops[e];
				end
			end
		end else if (r.cmd == CMD_NONE || s >= ENDPOINTS) begin
			v.status = ST_NOMATCH;
		end else if (r.cmd == CMD_WRITE) begin
			tbl_valid[s] = r.entry_valid;
			tbl_lip[s] = r.host_ip;
			tbl_lport[s] = r.host_port;
			tbl_ifc[s] = r.iface_index;
			tbl_rip[s] = r.remote_ip;
			tbl_rport[s] = r.remote_port;
			tbl_q[s] = '0;
			tbl_drops[s] = '0;
			v.status = ST_WRITTEN;
			v.slot = r.slot;
		end else begin
			if (!tbl_valid[s] || tbl_q[s] == '0) begin
				v.status = ST_EMPTY;
			end else begin
				tbl_q[s] = tbl_q[s] - QCNT_W'(1);
				v.status = ST_CONSUMED;
			end
			v.slot = r.slot;
			v.qcnt = tbl_q[s];
			v.drops = tbl_drops[s];
		end
		return v;
	endfunction

	function automatic dgram_req_t mk(input udq_cmd_t c, input int s, input bit ev,
			input logic [31:0] lip, input logic [15:0] lport, input logic [31:0] rip,
			input logic [15:0] rport, input int ifc, input int len);
		dgram_req_t r;
		r.cmd = c;
		r.slot = SLOT_W'(s);
		r.entry_valid = ev;
		r.host_ip = lip;
		r.host_port = lport;
		r.remote_ip = rip;
		r.remote_port = rport;
		r.iface_index = IFACE_W'(ifc);
		r.length = LEN_W'(len);
		return r;
	endfunction

	function automatic logic [15:0] port_pool();
		case ($urandom_range(4))
			0: return 16'd53;
			1: return 16'd5000;
			2: return 16'hFFFF;
			3: return 16'd1;
			default: return 16'($urandom_range(16'hFFFF, 1));
		endcase
	endfunction

	function automatic logic [31:0] ip_pool();
		case ($urandom_range(3))
			0: return 32'h0A00_0001;
			1: return 32'hC0A8_0001;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic dgram_req_t rand_item();
		dgram_req_t r;
		int pick;
		int e;
		int sel;
		r.slot = SLOT_W'($urandom);
		r.entry_valid = 1'($urandom);
		r.host_ip = $urandom;
		r.host_port = 16'($urandom);
		r.remote_ip = $urandom;
		r.remote_port = 16'($urandom);
		r.iface_index = IFACE_W'($urandom);
		r.length = LEN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			r.cmd = CMD_WRITE;
			r.entry_valid = ($urandom_range(99) < 85);
			r.host_port = ($urandom_range(99) < 8) ? 16'd0 : port_pool();
			r.host_ip = $urandom_range(1) ? 32'd0 : ip_pool();
			r.remote_ip = $urandom_range(1) ? 32'd0 : ip_pool();
			r.remote_port = $urandom_range(1) ? 16'd0 : port_pool();
			sel = $urandom_range(4);
			if (sel < 2)
				r.iface_index = IFACE_ANY;
			else if (sel < 4)
				r.iface_index = IFACE_W'($urandom_range(IFACES - 1));
			else
				r.iface_index = IFACE_W'($urandom_range(2**IFACE_W - 1, IFACES + 1));
		end else if (pick < 70) begin
			r.cmd = CMD_CLASSIFY;
			if ($urandom_range(99) < 80) begin
				e = $urandom_range(ENDPOINTS - 1);
				r.host_port = aim_lport[e];
				if (aim_lip[e] != '0)
					r.host_ip = aim_lip[e];
				if (aim_rip[e] != '0)
					r.remote_ip = aim_rip[e];
				if (aim_rport[e] != '0)
					r.remote_port = aim_rport[e];
				if (int'(aim_ifc[e]) < IFACES)
					r.iface_index = aim_ifc[e];
				if ($urandom_range(99) < 10)
					r.remote_port = r.remote_port + 16'd1;
			end
			sel = $urandom_range(99);
			if (sel < 70)
				r.length = LEN_W'($urandom_range(cfg_max_len));
			else if (sel < 85 && cfg_max_len != 16'hFFFF)
				r.length = LEN_W'($urandom_range(16'hFFFF, cfg_max_len + 1));
		end else if (pick < 95) begin
			r.cmd = CMD_CONSUME;
		end else begin
			r.cmd = CMD_NONE;
		end
		return r;
	endfunction

	task automatic queue_item(input dgram_req_t r);
		int s;
		s = int'(r.slot);
		if (r.cmd == CMD_WRITE && s < ENDPOINTS) begin
			aim_lip[s] = r.host_ip;
			aim_lport[s] = r.host_port;
			aim_ifc[s] = r.iface_index;
			aim_rip[s] = r.remote_ip;
			aim_rport[s] = r.remote_port;
		end
		dgram_q.push_back(r);
	endtask

	task automatic cfg_write(input int idx, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = 3'(4 * idx);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (idx == REG_MAX_LEN)
			tbl_max_len = data[LEN_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (dgram_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (ENDPOINTS + 4) @(posedge clk);
	endtask

	// source side
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (dgram_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					drv <= dgram_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// accept, predict and check
	always @(posedge clk) begin
		sock_verdict_t v;
		if (arst_n) begin
			in_took <= in_valid && in_ready;
			if (in_valid && in_ready)
				verdict_q.push_back(socket_lookup(drv));
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTED)
						$display("unexpected beat: st=%0d slot=%0d q=%0d drops=%0d",
							status, matched_slot, queued_count, drop_count);
				end else begin
					v = verdict_q.pop_front();
					if (status !== v.status || matched_slot !== v.slot ||
							queued_count !== v.qcnt || drop_count !== v.drops) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTED)
							$display("mismatch: exp st/slot/q/drops %0d/%0d/%0d/%0d, %s",
								v.status, v.slot, v.qcnt, v.drops,
								$sformatf("got %0d/%0d/%0d/%0d",
									status, matched_slot, queued_count, drop_count));
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int lens [4];
		int src_pct [4];
		int sink_pct [4];
		for (int e = 0; e < ENDPOINTS; e++) begin
			tbl_valid[e] = 1'b0;
			tbl_lip[e] = '0;
			tbl_lport[e] = '0;
			tbl_ifc[e] = IFACE_ANY;
			tbl_rip[e] = '0;
			tbl_rport[e] = '0;
			tbl_q[e] = '0;
			tbl_drops[e] = '0;
			aim_lip[e] = '0;
			aim_lport[e] = '0;
			aim_ifc[e] = IFACE_ANY;
			aim_rip[e] = '0;
			aim_rport[e] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, priority, interface rules, length limit, full queue
		queue_item(mk(CMD_CONSUME, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 32'h0A000001, 16'd53, 0, 0, 16, 0));
		queue_item(mk(CMD_NONE, 15, 1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 31, 16'hFFFF));
		queue_item(mk(CMD_WRITE, 3, 1, 0, 16'hFFFF, 0, 0, 16, 0));
		queue_item(mk(CMD_WRITE, 1, 1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 15, 0));
		queue_item(mk(CMD_WRITE, 2, 1, 0, 16'd7, 0, 0, 20, 0));
		queue_item(mk(CMD_WRITE, 4, 0, 0, 16'd9, 0, 0, 16, 0));
		queue_item(mk(CMD_WRITE, 5, 1, 0, 16'd0, 0, 0, 16, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 15, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 31, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 0, 16'd7, 0, 0, 20, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 0, 16'd9, 0, 0, 16, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 0, 16'd0, 0, 0, 16, 0));
		queue_item(mk(CMD_CLASSIFY, 0, 0, 0, 16'hFFFF, 0, 0, 16, 1473));
		for (int i = 0; i < 8; i++)
			queue_item(mk(CMD_CLASSIFY, 0, 0, 0, 16'hFFFF, 0, 0, 16, (i == 7) ? 16'hFFFF : 1472));
		queue_item(mk(CMD_CONSUME, 3, 0, 0, 0, 0, 0, 0, 0));
		queue_item(mk(CMD_CONSUME, 4, 0, 0, 0, 0, 0, 0, 0));
		wait_drained();

		lens = '{16'hFFFF, 0, $urandom_range(16'hFFFF), int'(MAXLEN_RST)};
		src_pct = '{0, 66, 0, 13};
		sink_pct = '{0, 0, 66, 13};
		for (int ph = 0; ph < 4; ph++) begin
			cfg_write(REG_MAX_LEN, lens[ph]);
			cfg_max_len = LEN_W'(lens[ph]);
			src_idle_pct = src_pct[ph];
			sink_stall_pct = sink_pct[ph];
			repeat (PHASE_ITEMS) queue_item(rand_item());
			wait_drained();
		end

		@(negedge clk);
		if (mismatch_cnt == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/udq_pkg.sv
hw/rtl/udq_cell.sv
hw/rtl/udp_endpoint_demux_queue_core.sv
hw/rtl/udq_checker.sv
sim/tb_top.sv
